[hdl/rc_pulse_channel_decoder_assert.svh]
// ----------------------------------------------------------------------------
// rc_pulse_channel_decoder_assert.svh
// Assertion macros shared by the pulse decoder modules.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_CHANNEL_DECODER_ASSERT_SVH
`define RC_PULSE_CHANNEL_DECODER_ASSERT_SVH

// check cons in the same cycle as ante
`define RCPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define RCPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/rcpd_pkg.sv]
// ----------------------------------------------------------------------------
// rcpd_pkg
// Shared types, register indexes and reset values of the RC pulse decoder.
// ----------------------------------------------------------------------------
package rcpd_pkg;

   localparam int ChannelCount = 4;

   localparam int CfgW    = 16;
   localparam int RegIdxW = 3;

   localparam logic [RegIdxW-1:0] REG_PULSE_MIN    = 3'd0;
   localparam logic [RegIdxW-1:0] REG_PULSE_MAX    = 3'd1;
   localparam logic [RegIdxW-1:0] REG_PULSE_CENTER = 3'd2;
   localparam logic [RegIdxW-1:0] REG_VALUE_TOP    = 3'd3;
   localparam logic [RegIdxW-1:0] REG_VALUE_BOTTOM = 3'd4;
   localparam logic [RegIdxW-1:0] REG_DEAD_BAND_A  = 3'd5;
   localparam logic [RegIdxW-1:0] REG_DEAD_BAND_B  = 3'd6;

   localparam logic [15:0]        RST_PULSE_MIN    = 16'd4800;
   localparam logic [15:0]        RST_PULSE_MAX    = 16'd10000;
   localparam logic [15:0]        RST_PULSE_CENTER = 16'd7425;
   localparam logic [14:0]        RST_VALUE_TOP    = 15'd100;
   localparam logic signed [15:0] RST_VALUE_BOTTOM = -16'sd100;
   localparam logic [13:0]        RST_DEAD_BAND_A  = 14'd100;
   localparam logic [13:0]        RST_DEAD_BAND_B  = 14'd75;

   typedef struct packed {
      logic [1:0]  channel;
      logic        level;
      logic [31:0] stamp;
   } req_type;

   typedef struct packed {
      logic [1:0]        out_channel;
      logic [15:0]       width;
      logic signed [15:0] position;
   } rsp_type;

   typedef struct packed {
      logic store_rise;
      logic load;
      logic calc_width;
      logic check_range;
      logic classify;
      logic mul;
      logic div_start;
      logic scale;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic present;
      logic is_rise;
      logic need_div;
      logic div_busy;
      logic rsp_free;
   } sts_type;

endpackage

[hdl/rcpd_div.sv]
// ----------------------------------------------------------------------------
// rcpd_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rcpd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [15:0] quotient
);

   logic        busy_ff;
   logic [4:0]  cnt_ff;
   logic [15:0] rem_ff;
   logic [31:0] quo_ff;
   logic [15:0] den_ff;
   logic [16:0] shifted;
   logic        fits;
   logic [16:0] diff;

   assign shifted = {rem_ff, quo_ff[31]};
   assign fits    = (shifted >= {1'b0, den_ff});
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[15:0] : shifted[15:0];
         quo_ff <= {quo_ff[30:0], fits};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff[15:0];

endmodule

[hdl/rcpd_dp.sv]
// ----------------------------------------------------------------------------
// rcpd_dp
// Datapath: settings, channel stamps, width measurement, band checks,
// scaling multiplier with serial divider, and the result register.
// ----------------------------------------------------------------------------
`include "rc_pulse_channel_decoder_assert.svh"

module rcpd_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rcpd_pkg::cmd_type             cmd,
   output rcpd_pkg::sts_type             sts,
   input  rcpd_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rcpd_pkg::rsp_type             rsp_data,
   input  logic                          csr_wen,
   input  logic [rcpd_pkg::RegIdxW-1:0]  csr_index,
   input  logic [rcpd_pkg::CfgW-1:0]     csr_wdata
);

   import rcpd_pkg::*;

   logic [15:0]        pulse_min_ff;
   logic [15:0]        pulse_max_ff;
   logic [15:0]        pulse_center_ff;
   logic [14:0]        value_top_ff;
   logic signed [15:0] value_bottom_ff;
   logic [13:0]        dead_a_ff;
   logic [13:0]        dead_b_ff;

   logic [31:0]        rise_ff [ChannelCount];
   logic signed [15:0] last_pos_ff [ChannelCount];

   logic [1:0]         ch_ff;
   logic [31:0]        stamp_ff;
   logic [31:0]        wfull_ff;
   logic signed [18:0] hi_ff;
   logic signed [18:0] lo_ff;
   logic [13:0]        dead_ff;
   logic [16:0]        w_ff;
   logic signed [15:0] pos_ff;
   logic [15:0]        op_a_ff;
   logic [15:0]        op_b_ff;
   logic [15:0]        den_ff;
   logic               neg_ff;
   logic [31:0]        prod_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [13:0]        dsel;
   logic signed [18:0] hi_in;
   logic signed [18:0] lo_in;
   logic               w_short;
   logic signed [18:0] wlo;
   logic               reject;
   logic signed [18:0] ws;
   logic signed [18:0] cs;
   logic signed [18:0] mxs;
   logic signed [18:0] mns;
   logic signed [18:0] ds;
   logic signed [18:0] up;
   logic signed [18:0] dn;
   logic               above;
   logic               below;
   logic               dead_up;
   logic               sat_up;
   logic               dead_dn;
   logic               sat_dn;
   logic [15:0]        bot_mag;
   logic [15:0]        span_up;
   logic [15:0]        span_dn;
   logic               div_busy;
   logic [15:0]        quotient;
   logic [15:0]        width_sat;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff    <= RST_PULSE_MIN;
         pulse_max_ff    <= RST_PULSE_MAX;
         pulse_center_ff <= RST_PULSE_CENTER;
         value_top_ff    <= RST_VALUE_TOP;
         value_bottom_ff <= RST_VALUE_BOTTOM;
         dead_a_ff       <= RST_DEAD_BAND_A;
         dead_b_ff       <= RST_DEAD_BAND_B;
      end else if (csr_wen) begin
         case (csr_index)
            REG_PULSE_MIN:    pulse_min_ff    <= csr_wdata;
            REG_PULSE_MAX:    pulse_max_ff    <= csr_wdata;
            REG_PULSE_CENTER: pulse_center_ff <= csr_wdata;
            REG_VALUE_TOP:    value_top_ff    <= csr_wdata[14:0];
            REG_VALUE_BOTTOM: value_bottom_ff <= $signed(csr_wdata);
            REG_DEAD_BAND_A:  dead_a_ff       <= csr_wdata[13:0];
            REG_DEAD_BAND_B:  dead_b_ff       <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // per-channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ChannelCount; i++) begin
            rise_ff[i]     <= '0;
            last_pos_ff[i] <= '0;
         end
      end else begin
         if (cmd.store_rise) begin
            rise_ff[req_data.channel] <= req_data.stamp;
         end
         if (cmd.emit) begin
            last_pos_ff[ch_ff] <= pos_ff;
         end
      end
   end

   // width and band limits
   assign dsel  = (ch_ff < 2'd2) ? dead_a_ff : dead_b_ff;
   assign hi_in = $signed({3'b000, pulse_max_ff}) + $signed({4'b0000, dsel, 1'b0});
   assign lo_in = $signed({3'b000, pulse_min_ff}) - $signed({4'b0000, dsel, 1'b0});

   assign w_short = (wfull_ff[31:18] == 14'd0);
   assign wlo     = $signed({1'b0, wfull_ff[17:0]});
   assign reject  = !w_short || (wlo > hi_ff) || (wlo < lo_ff);

   // classification around center
   assign ws  = $signed({2'b00, w_ff});
   assign cs  = $signed({3'b000, pulse_center_ff});
   assign mxs = $signed({3'b000, pulse_max_ff});
   assign mns = $signed({3'b000, pulse_min_ff});
   assign ds  = $signed({5'b00000, dead_ff});
   assign up  = ws - cs;
   assign dn  = cs - ws;

   assign above   = (ws > cs);
   assign below   = (ws < cs);
   assign dead_up = (up < ds);
   assign sat_up  = (ws > (mxs - ds));
   assign dead_dn = (dn < ds);
   assign sat_dn  = (ws < (mns + ds));

   assign bot_mag = value_bottom_ff[15] ? (16'd0 - $unsigned(value_bottom_ff))
                                        : $unsigned(value_bottom_ff);
   assign span_up = pulse_max_ff - pulse_center_ff;
   assign span_dn = pulse_center_ff - pulse_min_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff    <= req_data.channel;
         stamp_ff <= req_data.stamp;
      end
      if (cmd.calc_width) begin
         wfull_ff <= stamp_ff - rise_ff[ch_ff];
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         dead_ff  <= dsel;
      end
      if (cmd.check_range) begin
         w_ff <= reject ? {1'b0, pulse_center_ff} : wfull_ff[16:0];
      end
      if (cmd.classify) begin
         if (above) begin
            if (dead_up) begin
               w_ff   <= {1'b0, pulse_center_ff};
               pos_ff <= '0;
            end else if (sat_up) begin
               pos_ff <= $signed({1'b0, value_top_ff});
            end else begin
               op_a_ff <= {1'b0, value_top_ff};
               op_b_ff <= up[15:0];
               den_ff  <= span_up;
               neg_ff  <= 1'b0;
            end
         end else if (below) begin
            if (dead_dn) begin
               w_ff   <= {1'b0, pulse_center_ff};
               pos_ff <= '0;
            end else if (sat_dn) begin
               pos_ff <= value_bottom_ff;
            end else begin
               op_a_ff <= bot_mag;
               op_b_ff <= dn[15:0];
               den_ff  <= span_dn;
               neg_ff  <= value_bottom_ff[15];
            end
         end else begin
            pos_ff <= last_pos_ff[ch_ff];
         end
      end
      if (cmd.mul) begin
         prod_ff <= op_a_ff * op_b_ff;
      end
      if (cmd.scale) begin
         pos_ff <= neg_ff ? $signed(16'd0 - quotient) : $signed(quotient);
      end
   end

   rcpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // result register
   assign width_sat = w_ff[16] ? 16'hFFFF : w_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.out_channel <= ch_ff;
         rsp_data_ff.width       <= width_sat;
         rsp_data_ff.position    <= pos_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.present  = ({1'b0, req_data.channel} < 3'(ChannelCount));
   assign sts.is_rise  = req_data.level;
   assign sts.need_div = (above && !dead_up && !sat_up) || (below && !dead_dn && !sat_dn);
   assign sts.div_busy = div_busy;
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   `RCPD_ASSERT_NEXT(a_emit_shows_result, cmd.emit, rsp_valid_ff, "emitted item not presented")
   `RCPD_ASSERT_NOW(a_div_idle_on_mul, cmd.mul, !div_busy, "multiply while divider busy")

endmodule

[hdl/rcpd_ctl.sv]
// ----------------------------------------------------------------------------
// rcpd_ctl
// Sequencer for one edge item: store a rise stamp, or measure, range check, classify, scale if needed, emit.
// ----------------------------------------------------------------------------
`include "rc_pulse_channel_decoder_assert.svh"

module rcpd_ctl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rcpd_pkg::sts_type sts,
   output rcpd_pkg::cmd_type cmd
);

   import rcpd_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WIDTH = 4'd1;
   localparam logic [3:0] ST_RANGE = 4'd2;
   localparam logic [3:0] ST_CLASS = 4'd3;
   localparam logic [3:0] ST_MUL   = 4'd4;
   localparam logic [3:0] ST_DIV   = 4'd5;
   localparam logic [3:0] ST_WAIT  = 4'd6;
   localparam logic [3:0] ST_SCALE = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.present) begin
               if (sts.is_rise) begin
                  cmd.store_rise = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_WIDTH;
               end
            end
         end
         ST_WIDTH: begin
            cmd.calc_width = 1'b1;
            state_in       = ST_RANGE;
         end
         ST_RANGE: begin
            cmd.check_range = 1'b1;
            state_in        = ST_CLASS;
         end
         ST_CLASS: begin
            cmd.classify = 1'b1;
            state_in     = sts.need_div ? ST_MUL : ST_EMIT;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `RCPD_ASSERT_NOW(a_emit_needs_room, cmd.emit, sts.rsp_free, "emit into occupied output")
   `RCPD_ASSERT_NOW(a_start_div_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")

endmodule

[hdl/rc_pulse_channel_decoder.sv]
// ----------------------------------------------------------------------------
// rc_pulse_channel_decoder
// Four-channel RC servo pulse decoder: edge items in, width and position out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one edge item (channel, level, timer stamp). A rising edge
//   records its stamp and produces nothing. A falling edge yields
//   one rsp_* item: channel, accepted width in ticks and signed position.
//   csr_* writes the seven settings (min, max, center, top, bottom, two dead
//   bands); write only while the block is idle.
// Sequencing:
//   rising edge: stamp stored, next item accepted the following cycle.
//   falling edge: the width is measured, range checked and classified, then
//   the result is emitted directly when the width lands in the dead band, the
//   saturation zones or exactly on center; when scaled, the multiplier and
//   the 32-step serial divider run before scaling and emitting. One falling
//   edge is in work at a time; req_stall stays high until it is placed in the
//   output register.
// Reset: settings take their defaults, all stored rise stamps and positions
//   clear to zero, and the output register empties.
// Receiver stall: the result holds in the output register; one more falling
//   edge may be accepted and worked, then it waits for the register before emitting.
// ----------------------------------------------------------------------------
module rc_pulse_channel_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rcpd_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rcpd_pkg::rsp_type             rsp_data,
   input  logic                          csr_wen,
   input  logic [rcpd_pkg::RegIdxW-1:0]  csr_index,
   input  logic [rcpd_pkg::CfgW-1:0]     csr_wdata
);

   import rcpd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rcpd_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rcpd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
